// File: src/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg: shared constants and types
// Grid sizes, cell kinds, command and register codes for the imputation block.
// ----------------------------------------------------------------------------
package knn_pkg;
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 16;
  localparam int NEAREST = 3;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int DIST_W = 72;

  localparam logic [1:0] KIND_NUMBER = 2'd0;
  localparam logic [1:0] KIND_MISSING = 2'd1;
  localparam logic [1:0] KIND_TEXT = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_PATCHED = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [DIST_W-1:0] dsum;
    logic [ROW_W-1:0] idx;
  } pick_t;
endpackage

// File: src/knn_cell_ram.sv
// ----------------------------------------------------------------------------
// knn_cell_ram: grid cell store
// One write port and one registered read port; each word holds kind and value.
// ----------------------------------------------------------------------------
module knn_cell_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [knn_pkg::ADDR_W-1:0] waddr,
  input  logic [33:0]               wdata,
  input  logic [knn_pkg::ADDR_W-1:0] raddr,
  output logic [33:0]               rdata
);
  logic [33:0] mem [knn_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/knn_median_imputation.sv
// ----------------------------------------------------------------------------
// knn_median_imputation: nearest-row median imputation over a cell grid
// Stores a 64 x 16 grid and patches missing cells from their nearest rows.
// ----------------------------------------------------------------------------
// Usage: a slave stream carries requests. A write request (cmd 0) stores
// one cell and gives no result; the block passes through S_WRITE before it
// takes the next request. A query request (cmd 1) gives one result on the
// master stream. The user must let the configuration channel set
// rows_in_use and columns_in_use only while the block is idle; the block
// itself does not enforce it.
// A query outside the region in use goes straight to the output state; a
// query of a cell that is not missing reads that cell first. A missing cell
// walks every row in use through the single read port of the cell store,
// skipping the query row and rows whose cell in the query column is not a
// number; the median step sorts the values of the nearest rows. One
// subtract, one 32x32 multiply and one 72-bit add are shared across columns.
// The block takes one request at a time. A result waits in the output
// register while the receiver stalls; the block holds s_tready low while
// it works on a request, and a new result waits in the output state until
// the output register is free.
// Reset restores both registers to their full values and empties the
// output; the cell store keeps its contents and is undefined until written.
// ----------------------------------------------------------------------------
module knn_median_imputation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // fields from bit 0: cmd[0], row[6:1], column[10:7], kind[12:11], value[44:13]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // fields from bit 0: result_value[31:0], status[33:32], neighbours_used[35:34]
  output logic [39:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int RW = knn_pkg::ROW_W;
  localparam int CW = knn_pkg::COL_W;
  localparam int DW = knn_pkg::DIST_W;
  localparam int NW = $clog2(knn_pkg::NEAREST + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_QWAIT  = 4'd1;
  localparam logic [3:0] S_QCHK   = 4'd2;
  localparam logic [3:0] S_RCOL   = 4'd3;
  localparam logic [3:0] S_RCHK   = 4'd4;
  localparam logic [3:0] S_TRD    = 4'd5;
  localparam logic [3:0] S_CRD    = 4'd6;
  localparam logic [3:0] S_CMP    = 4'd7;
  localparam logic [3:0] S_MUL    = 4'd8;
  localparam logic [3:0] S_ACC    = 4'd9;
  localparam logic [3:0] S_INS    = 4'd10;
  localparam logic [3:0] S_VRD    = 4'd11;
  localparam logic [3:0] S_VGET   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;
  localparam logic [3:0] S_WRITE  = 4'd14;

  logic [3:0] state;
  logic [6:0] rows_in_use;
  logic [4:0] columns_in_use;
  logic [RW:0] nrows;
  logic [CW:0] ncols;

  logic [RW-1:0] q_row, r;
  logic [CW-1:0] q_col, c;
  logic [RW:0] r_cnt;
  logic [CW:0] c_cnt;
  logic [31:0] tval;
  logic [1:0] tkind;
  logic signed [32:0] diff;
  logic [31:0] mag;
  logic [63:0] sq;
  logic [DW-1:0] acc;

  knn_pkg::pick_t best [knn_pkg::NEAREST];
  logic [NW-1:0] count;
  logic [NW-1:0] ins_i;
  logic [31:0] vals [knn_pkg::NEAREST];
  logic [NW-1:0] v_i;
  logic [NW-1:0] v_j;

  logic we;
  logic [knn_pkg::ADDR_W-1:0] waddr, raddr;
  logic [33:0] wdata, rdata;
  logic [1:0] rkind;
  logic [31:0] rval;

  logic [31:0] out_value;
  logic [1:0] out_status, out_used;
  logic out_load;

  assign nrows = (rows_in_use > 7'(knn_pkg::MAX_ROWS)) ? (RW+1)'(knn_pkg::MAX_ROWS)
                                                        : (RW+1)'(rows_in_use);
  assign ncols = (columns_in_use > 5'(knn_pkg::MAX_COLS)) ? (CW+1)'(knn_pkg::MAX_COLS)
                                                           : (CW+1)'(columns_in_use);
  assign rkind = rdata[33:32];
  assign rval = rdata[31:0];
  assign s_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  knn_cell_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [1:0] wkind;
  assign wkind = (s_tdata[12:11] == 2'd3) ? knn_pkg::KIND_TEXT : s_tdata[12:11];

  always_comb begin
    raddr = {q_row, q_col};
    unique case (state)
      S_IDLE: raddr = {s_tdata[RW:1], s_tdata[7+CW-1:7]};
      S_RCOL: raddr = {r, q_col};
      S_TRD: raddr = {q_row, c};
      S_CRD: raddr = {r, c};
      S_VRD: raddr = {best[v_i].idx, q_col};
      S_VGET: raddr = {best[v_i].idx, q_col};
      default: raddr = {q_row, q_col};
    endcase
  end

  logic accept;
  assign accept = s_tvalid && s_tready;
  assign we = accept && (s_tdata[0] == knn_pkg::CMD_WRITE);
  assign waddr = {s_tdata[RW:1], s_tdata[7+CW-1:7]};
  assign wdata = {wkind, (wkind == knn_pkg::KIND_NUMBER) ? s_tdata[44:13] : 32'd0};

  logic [DW-1:0] acc_sum;
  assign acc_sum = acc + DW'(sq);
  assign mag = diff[32] ? 32'(-diff) : diff[31:0];
  logic less_last, less_prev;
  knn_pkg::pick_t cand;
  assign cand = '{dsum: acc, idx: r};
  assign less_last = cand.dsum < best[knn_pkg::NEAREST-1].dsum;
  assign less_prev = (ins_i != '0) && (cand.dsum < best[ins_i - 1'b1].dsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rows_in_use <= 7'd64;
      columns_in_use <= 5'd16;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == knn_pkg::REG_ROWS) rows_in_use <= cfg_data[6:0];
        else columns_in_use <= cfg_data[4:0];
      end
      unique case (state)
        S_IDLE: if (accept) begin
          q_row <= s_tdata[RW:1];
          q_col <= s_tdata[7+CW-1:7];
          if (s_tdata[0] == knn_pkg::CMD_WRITE) state <= S_WRITE;
          else if ((RW+1)'(s_tdata[RW:1]) >= nrows || (CW+1)'(s_tdata[7+CW-1:7]) >= ncols)
          begin
            out_value <= '0; out_status <= knn_pkg::ST_PRESENT; out_used <= '0;
            state <= S_OUT;
          end else state <= S_QWAIT;
        end
        S_WRITE: state <= S_IDLE;
        S_QWAIT: state <= S_QCHK;
        S_QCHK: begin
          if (rkind != knn_pkg::KIND_MISSING) begin
            out_value <= (rkind == knn_pkg::KIND_NUMBER) ? rval : 32'd0;
            out_status <= knn_pkg::ST_PRESENT; out_used <= '0;
            state <= S_OUT;
          end else begin
            r <= '0; r_cnt <= '0; count <= '0;
            state <= S_RCOL;
          end
        end
        S_RCOL: begin
          if (r_cnt >= nrows) begin
            if (count == '0) begin
              out_value <= '0; out_status <= knn_pkg::ST_NONE; out_used <= '0;
              state <= S_OUT;
            end else begin
              v_i <= '0;
              state <= S_VRD;
            end
          end else state <= S_RCHK;
        end
        S_RCHK: begin
          if (r == q_row || rkind != knn_pkg::KIND_NUMBER) begin
            r <= r + 1'b1; r_cnt <= r_cnt + 1'b1; state <= S_RCOL;
          end else begin
            c <= '0; c_cnt <= '0; acc <= '0; state <= S_TRD;
          end
        end
        S_TRD: begin
          if (c_cnt >= ncols) begin
            if (count < NW'(knn_pkg::NEAREST)) begin
              ins_i <= count; count <= count + 1'b1; state <= S_INS;
            end else if (less_last) begin
              ins_i <= NW'(knn_pkg::NEAREST - 1); state <= S_INS;
            end else begin
              r <= r + 1'b1; r_cnt <= r_cnt + 1'b1; state <= S_RCOL;
            end
          end else state <= S_CRD;
        end
        S_CRD: begin
          tkind <= rkind; tval <= rval;
          state <= S_CMP;
        end
        S_CMP: begin
          if (tkind != knn_pkg::KIND_NUMBER) begin
            c <= c + 1'b1; c_cnt <= c_cnt + 1'b1; state <= S_TRD;
          end else if (rkind != knn_pkg::KIND_NUMBER) begin
            r <= r + 1'b1; r_cnt <= r_cnt + 1'b1; state <= S_RCOL;
          end else begin
            diff <= 33'(signed'(rval)) - 33'(signed'(tval));
            state <= S_MUL;
          end
        end
        S_MUL: begin
          sq <= 64'(mag) * 64'(mag);
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc_sum;
          c <= c + 1'b1; c_cnt <= c_cnt + 1'b1; state <= S_TRD;
        end
        S_INS: begin
          // Shift larger entries down one slot per cycle; equals stay ahead.
          if (less_prev) begin
            best[ins_i] <= best[ins_i - 1'b1];
            ins_i <= ins_i - 1'b1;
          end else begin
            best[ins_i] <= cand;
            r <= r + 1'b1; r_cnt <= r_cnt + 1'b1; state <= S_RCOL;
          end
        end
        S_VRD: begin
          v_j <= v_i; state <= S_VGET;
        end
        S_VGET: begin
          if (v_j != '0 && $signed(vals[v_j - 1'b1]) > $signed(rval)) begin
            vals[v_j] <= vals[v_j - 1'b1];
            v_j <= v_j - 1'b1;
          end else begin
            vals[v_j] <= rval;
            if (v_i + 1'b1 == count) begin
              state <= S_OUT;
              out_status <= knn_pkg::ST_PATCHED;
              out_used <= (count > NW'(3)) ? 2'd3 : 2'(count);
            end else begin
              v_i <= v_i + 1'b1; state <= S_VRD;
            end
          end
        end
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // The output register keeps the last result while the next request runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      m_tdata <= {4'd0, out_used, out_status,
                  (out_status == knn_pkg::ST_PATCHED) ? vals[count >> 1] : out_value};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end
endmodule

// File: src/knn_median_imputation_checker.sv
// ----------------------------------------------------------------------------
// knn_median_imputation_checker: port-level checks
// Watches the streams of the imputation block and flags protocol slips.
// ----------------------------------------------------------------------------
module knn_median_imputation_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  // A taken request keeps the block busy, so s_tready drops after it.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken on back-to-back cycles");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:32] != 2'd3)
    else $error("bad status code");
  a_used: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] != 2'd0 |-> m_tdata[35:34] == 2'd0)
    else $error("neighbours without patch");
endmodule

bind knn_median_imputation knn_median_imputation_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
